@@ hdl/balu_pkg.sv @@
// Package: opcodes, status codes and payload types of the byte ALU.
`timescale 1ns / 1ps
`default_nettype none
package balu_pkg;

  typedef enum logic [2:0] {
    OpIntAdd   = 3'd0,
    OpFloatAdd = 3'd1,
    OpOr       = 3'd2,
    OpAnd      = 3'd3,
    OpXor      = 3'd4,
    OpRotR     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StZero  = 2'd1,
    StOver  = 2'd2,
    StUnder = 2'd3
  } fstat_e;

  localparam int unsigned ExpBias = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result;
    logic [1:0] float_status;
  } out_item_t;

endpackage
`default_nettype wire

@@ hdl/byte_alu_with_minifloat_add.sv @@
// Byte ALU with integer, logic, rotate and 8-bit minifloat add.
// Two register stages (input reg, result reg); an accepted item moves on from the
// input reg to the result reg when the result stage advances.
// Throughput: one item per cycle unless the output stalls; a stage advances when the
// one after it is empty or being taken, so both stages hold items concurrently.
// Reset: asynchronous, active low; clears the valid flags only.
`timescale 1ns / 1ps
`default_nettype none
module byte_alu_with_minifloat_add (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  balu_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output balu_pkg::out_item_t  out_item_o
);
  import balu_pkg::*;

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res_q;
  logic      res_vld_q;
  logic      res_adv;

  assign res_adv     = !res_vld_q || out_ready_i;
  assign in_ready_o  = !in_vld_q || res_adv;
  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;

  // Minifloat operands as signed values scaled by 2^8: +/-(16+f) << e
  logic [11:0] mag_a, mag_b;
  logic [13:0] sa, sb, sum;
  logic [12:0] mag;
  logic [3:0]  p;
  logic [7:0]  fres;
  fstat_e      fst;
  logic [7:0]  sgn;
  logic [2:0]  e;
  logic [12:0] shf;

  always_comb begin
    mag_a = 12'({1'b1, in_q.operand_a[3:0]}) << in_q.operand_a[6:4];
    mag_b = 12'({1'b1, in_q.operand_b[3:0]}) << in_q.operand_b[6:4];
    sa    = in_q.operand_a[7] ? -{2'b00, mag_a} : {2'b00, mag_a};
    sb    = in_q.operand_b[7] ? -{2'b00, mag_b} : {2'b00, mag_b};
    sum   = sa + sb;
    mag   = sum[13] ? 13'(-sum) : sum[12:0];
    sgn   = {sum[13], 7'd0};
    // leading-one position
    p = 4'd0;
    for (int i = 0; i < 13; i++) begin
      if (mag[i]) p = 4'(i);
    end
    e    = 3'(p - 4'(ExpBias));
    shf  = mag >> e;
    fres = 8'd0;
    fst  = StOk;
    if (sum == 14'd0) begin
      fst = StZero;
    end else if (p < 4'(ExpBias)) begin
      fst  = StUnder;
      fres = sgn;
    end else if (p > 4'(ExpBias + 7)) begin
      fst  = StOver;
      fres = sgn | 8'h7F;
    end else begin
      fres = sgn | {1'b0, e, shf[3:0]};
    end
  end

  // Operation select
  out_item_t res_d;
  logic [15:0] rot2;
  always_comb begin
    rot2  = {in_q.operand_a, in_q.operand_a} >> in_q.operand_b[2:0];
    res_d = '0;
    case (in_q.kind)
      OpIntAdd:   res_d.result = in_q.operand_a + in_q.operand_b;
      OpFloatAdd: begin
        res_d.result       = fres;
        res_d.float_status = fst;
      end
      OpOr:       res_d.result = in_q.operand_a | in_q.operand_b;
      OpAnd:      res_d.result = in_q.operand_a & in_q.operand_b;
      OpXor:      res_d.result = in_q.operand_a ^ in_q.operand_b;
      OpRotR:     res_d.result = rot2[7:0];
      default:    res_d = '0;
    endcase
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (res_adv) res_vld_q <= in_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
    if (res_adv && in_vld_q) res_q <= res_d;
  end

endmodule
`default_nettype wire

@@ tb/byte_alu_with_minifloat_add_tb.sv @@
// Byte ALU testbench: directed rows, random items; checked against typed or predicted values.
`timescale 1ns / 1ps
`default_nettype none
module byte_alu_with_minifloat_add_tb;
  import balu_pkg::*;

  // Directed row: expected value typed in only where flagged.
  typedef struct {
    logic [2:0] kind;
    logic [7:0] a;
    logic [7:0] b;
    bit         typed;
    logic [7:0] res;
    logic [1:0] st;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  out_item_t alu_expected_q[$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_float = 0;
  int        n_sent = 0;
  bit        stim_done = 1'b0;
  row_t      rows[$];

  byte_alu_with_minifloat_add DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Value of a minifloat scaled by 2^8.
  function automatic int mf_value(logic [7:0] x);
    int mag;
    mag = (16 + x[3:0]) << x[6:4];
    return x[7] ? -mag : mag;
  endfunction

  function automatic out_item_t alu_predict(logic [2:0] kind, logic [7:0] a,
                                            logic [7:0] b);
    out_item_t   r;
    int          sum;
    int          mag;
    int          p;
    logic [7:0]  sgn;
    logic [2:0]  amt;
    logic [15:0] rot;
    r = '0;
    case (kind)
      OpIntAdd: r.result = a + b;
      OpOr:     r.result = a | b;
      OpAnd:    r.result = a & b;
      OpXor:    r.result = a ^ b;
      OpRotR: begin
        amt = b[2:0];
        rot = {a, a} >> amt;
        r.result = rot[7:0];
      end
      OpFloatAdd: begin
        sum = mf_value(a) + mf_value(b);
        sgn = (sum < 0) ? 8'h80 : 8'h00;
        mag = (sum < 0) ? -sum : sum;
        p = 0;
        while ((mag >> (p + 1)) != 0) p++;
        if (sum == 0) begin
          r.float_status = StZero;
        end else if (p < ExpBias) begin
          r.result = sgn;
          r.float_status = StUnder;
        end else if (p - ExpBias > 7) begin
          r.result = sgn | 8'h7F;
          r.float_status = StOver;
        end else begin
          r.result = sgn | 8'((p - ExpBias) << 4) | 8'(((mag >> (p - ExpBias)) - 16) & 15);
          r.float_status = StOk;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    n_errors++;
  endtask

  task automatic add_row(logic [2:0] k, logic [7:0] a, logic [7:0] b, bit typed = 0,
                         logic [7:0] res = 0, logic [1:0] st = 0);
    row_t r;
    r.kind = k; r.a = a; r.b = b; r.typed = typed; r.res = res; r.st = st;
    rows.push_back(r);
  endtask

  // Offer one item on the falling edge and hold until accepted.
  task automatic send_item(logic [2:0] k, logic [7:0] a, logic [7:0] b, out_item_t exp_item);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i.kind = k;
    in_item_i.operand_a = a;
    in_item_i.operand_b = b;
    in_valid_i <= 1'b1;
    alu_expected_q.push_back(exp_item);
    if (k == OpFloatAdd) n_float++;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Stimulus: directed table, then random items.
  initial begin
    int      k;
    logic [2:0] kind;
    logic [7:0] a;
    logic [7:0] b;
    out_item_t  e;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    add_row(OpIntAdd, 8'hFF, 8'h01, 1, 8'h00, StOk);
    add_row(OpIntAdd, 8'h7F, 8'h7F, 1, 8'hFE, StOk);
    add_row(OpOr, 8'hF0, 8'h0F, 1, 8'hFF, StOk);
    add_row(OpAnd, 8'hFF, 8'h00, 1, 8'h00, StOk);
    add_row(OpXor, 8'hAA, 8'hFF, 1, 8'h55, StOk);
    add_row(OpRotR, 8'h81, 8'h00, 1, 8'h81, StOk);
    add_row(OpRotR, 8'h01, 8'h01, 1, 8'h80, StOk);
    add_row(OpRotR, 8'h96, 8'hFF);
    add_row(OpRotR, 8'h96, 8'hFB);
    add_row(OpFloatAdd, 8'h40, 8'hC0, 1, 8'h00, StZero);
    add_row(OpFloatAdd, 8'h7F, 8'h7F, 1, 8'h7F, StOver);
    add_row(OpFloatAdd, 8'hFF, 8'hFF, 1, 8'hFF, StOver);
    add_row(OpFloatAdd, 8'h01, 8'h80, 1, 8'h00, StUnder);
    add_row(OpFloatAdd, 8'h81, 8'h00, 1, 8'h80, StUnder);
    add_row(OpFloatAdd, 8'h00, 8'h00, 1, 8'h10, StOk);
    add_row(OpFloatAdd, 8'h4F, 8'h41);
    add_row(OpFloatAdd, 8'h3A, 8'hB5);
    add_row(OpFloatAdd, 8'h70, 8'hE0);
    add_row(3'd6, 8'hFF, 8'hFF, 1, 8'h00, StOk);
    add_row(3'd7, 8'h12, 8'h34, 1, 8'h00, StOk);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        e.result = rows[i].res;
        e.float_status = rows[i].st;
      end else begin
        e = alu_predict(rows[i].kind, rows[i].a, rows[i].b);
      end
      send_item(rows[i].kind, rows[i].a, rows[i].b, e);
    end
    // Random part; float adds weighted up since they hold the odd cases.
    for (k = 0; k < 600; k++) begin
      kind = ($urandom_range(0, 2) == 0) ? 3'(OpFloatAdd) : 3'($urandom_range(0, 7));
      a = $urandom;
      b = $urandom;
      send_item(kind, a, b, alu_predict(kind, a, b));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off early in the run.
  initial begin
    int wait_cycles;
    @(posedge rst_ni);
    repeat (60) @(negedge clk_i);
    out_ready_i <= 1'b0;
    repeat (200) @(negedge clk_i);
    forever begin
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alu_expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_item_o, 0);
      end else begin
        want = alu_expected_q.pop_front();
        n_checked++;
        if (out_item_o.result !== want.result)
          report_mismatch("result", out_item_o.result, want.result);
        if (out_item_o.float_status !== want.float_status)
          report_mismatch("float_status", out_item_o.float_status, want.float_status);
      end
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (alu_expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("checked %0d results from %0d items, %0d of them float adds,", n_checked,
             n_sent, n_float);
    $display("with random stalls on both sides and one long output hold-off");
    if (n_errors == 0 && alu_expected_q.size() == 0) begin
      $display("[byte_alu_with_minifloat_add] OK");
    end else begin
      $display("[byte_alu_with_minifloat_add] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("[byte_alu_with_minifloat_add] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
